// File: rtl/mexp_pkg.sv
// Shared types for the modular exponentiation block.
// Holds the operation codes and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  // Operation that the shared modular multiply unit is running.
  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,
    OP_MUL    = 2'd1,
    OP_SQR    = 2'd2
  } op_e;

  typedef struct packed {
    logic load;      // capture a new input item
    logic setup;     // prepare operands for a multiply
    logic step;      // advance the multiply by one multiplier bit
    logic wb;        // write the finished product back
    logic out_load;  // move the result into the output register
    op_e  op;        // operation for setup and wb
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_last;  // multiply is on its last bit
    logic e_zero;    // no exponent bits left
    logic e_lsb;     // current exponent bit
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: controller plus datapath.
// Depends on mexp_pkg, mexp_controller and mexp_datapath.
//
// Usage: an input transfer (in_valid_i & in_ready_o) brings base_i, exponent_i
// and modulus_i. One output transfer (out_valid_o & out_ready_i) returns
// power_mod_o = base^exponent mod modulus. A modulus of zero returns zero.
// One item is processed at a time; in_ready_o is high only while the engine is idle.
// Sequence: the base is first reduced modulo the modulus. Each exponent bit up to
// the highest set one then takes a squaring, plus a multiply when the bit is set,
// all on the one bit-serial modular multiplier (one multiplier bit per cycle).
// A load step comes first and an output step completes it.
// The output register decouples the sides: a waiting result does not stop a
// new input transfer, and the engine holds its result until the output
// register frees up when the receiver stalls. Reset empties the output
// register and returns the engine to idle.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation #(
  parameter int MOD_WIDTH = 32,
  parameter int EXP_WIDTH = 63
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [MOD_WIDTH-1:0] base_i,
  input  wire logic [EXP_WIDTH-1:0] exponent_i,
  input  wire logic [MOD_WIDTH-1:0] modulus_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [MOD_WIDTH-1:0] power_mod_o
);

  mexp_pkg::ctrl_cmd_t  cmd;
  mexp_pkg::dp_status_t status;

  // Sequencing and handshakes.
  mexp_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Operand registers and the shared serial multiplier.
  mexp_datapath #(
    .MOD_WIDTH (MOD_WIDTH),
    .EXP_WIDTH (EXP_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .base_i      (base_i),
    .exponent_i  (exponent_i),
    .modulus_i   (modulus_i),
    .power_mod_o (power_mod_o)
  );

  // An accepted item keeps the engine busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("engine ready right after an input transfer");

  // A result is always below the modulus, so it never reaches all ones.
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> power_mod_o != {MOD_WIDTH{1'b1}})
    else $error("result out of range");

  // A new result only appears from a busy engine.
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result produced while idle");

endmodule

`default_nettype wire

// File: rtl/mexp_datapath.sv
// Datapath of the modular exponentiation block: operand registers and a
// bit-serial interleaved modular multiplier. Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mexp_datapath #(
  parameter int MOD_WIDTH = 32,
  parameter int EXP_WIDTH = 63
) (
  input  wire logic                      clk_i,
  input  wire mexp_pkg::ctrl_cmd_t       cmd_i,
  output mexp_pkg::dp_status_t           status_o,
  input  wire logic [MOD_WIDTH-1:0]      base_i,
  input  wire logic [EXP_WIDTH-1:0]      exponent_i,
  input  wire logic [MOD_WIDTH-1:0]      modulus_i,
  output logic      [MOD_WIDTH-1:0]      power_mod_o
);

  localparam int CntW = $clog2(MOD_WIDTH);

  logic [MOD_WIDTH-1:0] m_q, a_q, mb_q, p_q, acc_q, sq_q, power_mod_q;
  logic [EXP_WIDTH-1:0] e_q;
  logic [CntW-1:0]      cnt_q;
  logic                 m_zero_q;
  logic [MOD_WIDTH-1:0] dbl, p_d;

  // (x + y) mod m for x, y < m, exact at one extra bit.
  function automatic logic [MOD_WIDTH-1:0] add_mod(input logic [MOD_WIDTH-1:0] x,
                                                   input logic [MOD_WIDTH-1:0] y,
                                                   input logic [MOD_WIDTH-1:0] m);
    logic [MOD_WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[MOD_WIDTH-1:0];
  endfunction

  // Double the partial product, then add the addend when the multiplier bit is set.
  assign dbl = add_mod(p_q, p_q, m_q);
  assign p_d = mb_q[MOD_WIDTH-1] ? add_mod(dbl, a_q, m_q) : dbl;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q      <= modulus_i;
      m_zero_q <= (modulus_i == '0);
      e_q      <= exponent_i;
      a_q      <= MOD_WIDTH'(1);
      mb_q     <= base_i;
      p_q      <= '0;
      cnt_q    <= '0;
      acc_q    <= (modulus_i == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
    end else if (cmd_i.setup) begin
      a_q   <= (cmd_i.op == mexp_pkg::OP_MUL) ? acc_q : sq_q;
      mb_q  <= sq_q;
      p_q   <= '0;
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      p_q   <= p_d;
      mb_q  <= {mb_q[MOD_WIDTH-2:0], 1'b0};
      cnt_q <= cnt_q + CntW'(1);
    end else if (cmd_i.wb) begin
      case (cmd_i.op)
        mexp_pkg::OP_REDUCE: sq_q <= p_q;
        mexp_pkg::OP_MUL:    acc_q <= p_q;
        mexp_pkg::OP_SQR: begin
          sq_q <= p_q;
          e_q  <= e_q >> 1;
        end
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      power_mod_q <= m_zero_q ? '0 : acc_q;
    end
  end

  assign status_o.cnt_last = (cnt_q == CntW'(MOD_WIDTH - 1));
  assign status_o.e_zero   = (e_q == '0);
  assign status_o.e_lsb    = e_q[0];
  assign power_mod_o       = power_mod_q;

endmodule

`default_nettype wire

// File: rtl/mexp_controller.sv
// Controller of the modular exponentiation block: sequences reduction,
// multiplies and squarings, and owns the handshakes. Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mexp_controller (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire mexp_pkg::dp_status_t  status_i,
  output mexp_pkg::ctrl_cmd_t        cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRun  = 3'd1;
  localparam logic [2:0] StWb   = 3'd2;
  localparam logic [2:0] StPick = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]        state_q, state_d;
  mexp_pkg::op_e     op_q, op_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = op_q;
    state_d     = state_q;
    op_d        = op_q;
    in_ready_o  = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = mexp_pkg::OP_REDUCE;
          state_d    = StRun;
        end
      end
      StRun: begin
        cmd_o.step = 1'b1;
        if (status_i.cnt_last) begin
          state_d = StWb;
        end
      end
      StWb: begin
        cmd_o.wb = 1'b1;
        state_d  = StPick;
      end
      StPick: begin
        if (op_q == mexp_pkg::OP_MUL) begin
          op_d = mexp_pkg::OP_SQR;
        end else if (!status_i.e_zero && status_i.e_lsb) begin
          op_d = mexp_pkg::OP_MUL;
        end else begin
          op_d = mexp_pkg::OP_SQR;
        end
        if (op_q != mexp_pkg::OP_MUL && status_i.e_zero) begin
          state_d = StOut;
        end else begin
          cmd_o.setup = 1'b1;
          cmd_o.op    = op_d;
          state_d     = StRun;
        end
      end
      StOut: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= mexp_pkg::OP_REDUCE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the modular_exponentiation block.
// Needs only the RTL under rtl/ (mexp_pkg, mexp_controller, mexp_datapath and the modular_exponentiation top level).
`timescale 1ns / 1ps

module testbench;

  localparam int MOD_WIDTH = 32;
  localparam int EXP_WIDTH = 63;
  // Slowest item: one reduction plus a square and a multiply for every exponent bit.
  localparam int ITEM_CYCLES = 2 + (MOD_WIDTH + 2) * (1 + 2 * EXP_WIDTH);
  localparam int RANDOM_JOBS = 130;

  typedef struct {
    logic [MOD_WIDTH-1:0] base;
    logic [EXP_WIDTH-1:0] exponent;
    logic [MOD_WIDTH-1:0] modulus;
    bit                   wait_idle;  // hold this job back until every result is in
  } exp_job_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MOD_WIDTH-1:0] base = '0;
  logic [EXP_WIDTH-1:0] exponent = '0;
  logic [MOD_WIDTH-1:0] modulus = '1;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [MOD_WIDTH-1:0] power_mod;

  exp_job_t             pending_jobs[$];
  logic [MOD_WIDTH-1:0] power_mod_expect[$];
  int unsigned          mismatch_count = 0;
  int unsigned          result_index = 0;
  int unsigned          send_gap = 0;
  int unsigned          recv_stall = 0;
  bit                   send_calm = 1'b0;
  bit                   recv_calm = 1'b0;

  modular_exponentiation #(
    .MOD_WIDTH(MOD_WIDTH),
    .EXP_WIDTH(EXP_WIDTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .base_i     (base),
    .exponent_i (exponent),
    .modulus_i  (modulus),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .power_mod_o(power_mod)
  );

  always #2 clk = ~clk;

  // Compute base^exponent mod modulus with exact double-width products.
  // A zero modulus answers zero; a modulus of one folds every value to zero.
  function automatic logic [MOD_WIDTH-1:0] predict_power_mod(
    input logic [MOD_WIDTH-1:0] b,
    input logic [EXP_WIDTH-1:0] e,
    input logic [MOD_WIDTH-1:0] m
  );
    logic [2*MOD_WIDTH-1:0] wide_m;
    logic [2*MOD_WIDTH-1:0] acc;
    logic [2*MOD_WIDTH-1:0] sq;
    logic [EXP_WIDTH-1:0]   bits_left;
    if (m == '0) return '0;
    wide_m    = {{MOD_WIDTH{1'b0}}, m};
    acc       = {{(2*MOD_WIDTH-1){1'b0}}, 1'b1};
    acc       = acc % wide_m;
    sq        = {{MOD_WIDTH{1'b0}}, b};
    sq        = sq % wide_m;
    bits_left = e;
    // Walk the exponent from its low end: multiply on set bits, square always.
    while (bits_left != '0) begin
      if (bits_left[0]) acc = (acc * sq) % wide_m;
      sq        = (sq * sq) % wide_m;
      bits_left = bits_left >> 1;
    end
    return acc[MOD_WIDTH-1:0];
  endfunction

  task automatic push_job(input logic [MOD_WIDTH-1:0] b, input logic [EXP_WIDTH-1:0] e,
                          input logic [MOD_WIDTH-1:0] m, input bit hold);
    exp_job_t job;
    job.base      = b;
    job.exponent  = e;
    job.modulus   = m;
    job.wait_idle = hold;
    pending_jobs.insert(pending_jobs.size(), job);
  endtask

  // Count every failure; print only the first ten.
  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at result %0d: %s", result_index, what);
  endtask

  // Driver: present one pending job at a time, hold it until the transfer,
  // then wait a random number of cycles before the next one.
  always @(posedge clk or negedge rst_n) begin : drive_jobs
    logic     next_valid;
    exp_job_t job;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        power_mod_expect.insert(power_mod_expect.size(),
                                predict_power_mod(base, exponent, modulus));
        next_valid = 1'b0;
        // Flip now and then into a stretch with no gaps at all.
        if ($urandom_range(0, 11) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 3);
      end
      if (!next_valid && pending_jobs.size() != 0) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (!pending_jobs[0].wait_idle || power_mod_expect.size() == 0) begin
          job = pending_jobs.pop_front();
          base       <= job.base;
          exponent   <= job.exponent;
          modulus    <= job.modulus;
          next_valid = 1'b1;
        end
      end
      // Assign valid once per edge so a back-to-back job keeps it high.
      in_valid <= next_valid;
    end
  end

  // Monitor: check each result transfer against the oldest expectation, then
  // draw a stall that applies once the next result shows up.
  always @(posedge clk or negedge rst_n) begin : check_results
    logic                 next_ready;
    logic [MOD_WIDTH-1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      next_ready = out_ready;
      if (out_valid && out_ready) begin
        if (power_mod_expect.size() == 0) begin
          note_mismatch($sformatf("unexpected result power_mod=%0h", power_mod));
        end else begin
          want = power_mod_expect.pop_front();
          if (power_mod !== want)
            note_mismatch($sformatf("power_mod expected %0h, got %0h", want, power_mod));
        end
        result_index++;
        if ($urandom_range(0, 11) == 0) recv_calm = !recv_calm;
        recv_stall = recv_calm ? 0 : $urandom_range(0, 3);
        next_ready = (recv_stall == 0);
      end else if (out_valid && !out_ready) begin
        // Count down the stall only while a result is waiting.
        if (recv_stall != 0) recv_stall--;
        if (recv_stall == 0) next_ready = 1'b1;
      end
      out_ready <= next_ready;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    logic [MOD_WIDTH-1:0] r_base;
    logic [MOD_WIDTH-1:0] r_mod;
    logic [63:0]          r_wide;
    logic [EXP_WIDTH-1:0] r_exp;
    bit                   r_hold;

    // Directed: extremes and the special cases.
    push_job(32'd5, '0, 32'd7, 1'b0);                      // zero exponent
    push_job(32'd5, '0, 32'd1, 1'b0);                      // zero exponent, unit modulus
    push_job(32'd0, '0, 32'd13, 1'b0);                     // zero to the zero
    push_job(32'd0, 63'd5, 32'd13, 1'b0);                  // zero base
    push_job('1, '1, 32'd1, 1'b0);                         // unit modulus, full exponent
    push_job('1, '1, '1, 1'b0);                            // all fields at maximum
    push_job('1, 63'd1, '1, 1'b0);                         // base folds to zero
    push_job(32'hFFFF_FFFE, '1, '1, 1'b0);                 // base is minus one
    push_job(32'd2, 63'd4294967290, 32'd4294967291, 1'b0); // Fermat: gives one
    push_job(32'd3, '1, 32'd1000000007, 1'b0);
    push_job(32'd7, {1'b1, {(EXP_WIDTH-1){1'b0}}}, 32'hFFFF_FFFB, 1'b0); // top bit only
    push_job(32'd12345, 63'd1, 32'd100, 1'b0);             // exponent of one, base above modulus
    push_job(32'd3, 63'd63, 32'h8000_0000, 1'b0);          // power-of-two modulus
    push_job('1, 63'h2AAA_AAAA_AAAA_AAAA, 32'd2, 1'b0);
    push_job(32'hDEAD_BEEF, 63'h5555_5555_5555_5555, 32'hCAFE_F00D, 1'b0);
    push_job(32'd9, 63'd17, 32'd0, 1'b0);                  // zero modulus answers zero
    push_job(32'h8000_0001, 63'd2, 32'h7FFF_FFFF, 1'b1);   // wait for idle first

    // Random: mostly full-range content, with short exponents and narrow moduli mixed in.
    for (int n = 0; n < RANDOM_JOBS; n++) begin
      r_base = $urandom;
      r_mod  = $urandom;
      r_wide = {$urandom, $urandom};
      r_exp  = r_wide[EXP_WIDTH-1:0];
      if ($urandom_range(0, 1) == 0) r_exp = r_exp >> $urandom_range(1, EXP_WIDTH - 1);
      if ($urandom_range(0, 2) == 0) r_mod = r_mod >> $urandom_range(1, MOD_WIDTH - 1);
      if ($urandom_range(0, 39) == 0) r_mod = 32'd1;
      if ($urandom_range(0, 39) == 0) r_exp = '0;
      if (r_mod == '0) r_mod = 32'd1;
      if ($urandom_range(0, 2) == 0) r_base = r_base % r_mod;
      r_hold = (n == RANDOM_JOBS / 2) || ($urandom_range(0, 29) == 0);
      push_job(r_base, r_exp, r_mod, r_hold);
    end

    // Hold reset, then release it away from the rising edge.
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Drain: all jobs transferred and every expectation met.
    do @(posedge clk);
    while (pending_jobs.size() != 0 || in_valid || power_mod_expect.size() != 0);
    // Let any stray result show up before judging.
    repeat (2 * (MOD_WIDTH + 2)) @(posedge clk);

    if (mismatch_count == 0 && power_mod_expect.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #(64'd8 * (RANDOM_JOBS + 20) * (ITEM_CYCLES + 8) * 4);
    $display("FAIL");
    $finish;
  end

endmodule
